[hdl/csvre_pkg.sv]
// ----------------------------------------------------------------------------
// CSV record end finder package
// Shared widths, payload structs, register indexes and byte helpers.
// ----------------------------------------------------------------------------
package csvre_pkg;

    localparam int OFFSET_WIDTH = 32;
    localparam int CMP_WIDTH    = (OFFSET_WIDTH > 32) ? OFFSET_WIDTH : 32;
    localparam int CFG_IDX_W    = 1;

    localparam logic [7:0] QUOTE_CH = 8'h22;
    localparam logic [7:0] NL_CH    = 8'h0A;

    localparam logic [7:0]  SEP_RESET = 8'd44;
    localparam logic [31:0] CAP_RESET = 32'd1048576;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEPARATOR = 1'b0,
        CFG_MAX_BYTES = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_QUOTED_NL    = 2'd0,
        KIND_DATA_END     = 2'd1,
        KIND_FALLBACK_NL  = 2'd2,
        KIND_FALLBACK_END = 2'd3
    } t_kind;

    typedef struct packed {
        logic       byte_present;
        logic [7:0] data_byte;
        logic       scan_start;
        logic       data_end;
    } t_in;

    typedef struct packed {
        logic [31:0] end_offset;
        t_kind       end_kind;
    } t_out;

    typedef struct packed {
        logic [7:0]  separator_char;
        logic [31:0] max_record_bytes;
    } t_cfg;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic over_cap(input logic [OFFSET_WIDTH-1:0] r,
                                      input logic [31:0] cap);
        logic [CMP_WIDTH-1:0] r_ext;
        logic [CMP_WIDTH-1:0] cap_ext;
        r_ext   = CMP_WIDTH'(r);
        cap_ext = CMP_WIDTH'(cap);
        return r_ext > cap_ext;
    endfunction

endpackage

[hdl/csvre_framer.sv]
// ----------------------------------------------------------------------------
// CSV record framer
// Holds the scan state and works out the next state and any result for one
// accepted beat in a single pass of logic.
// ----------------------------------------------------------------------------
module csvre_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  csvre_pkg::t_in      i_item,
    input  csvre_pkg::t_cfg     i_cfg,
    output logic                o_emit,
    output csvre_pkg::t_out     o_result
);

    typedef struct packed {
        logic                                  inside_quoted;
        logic                                  quote_pending;
        logic                                  cell_was_quoted;
        logic                                  cell_only_space;
        logic                                  at_resume_point;
        logic [csvre_pkg::OFFSET_WIDTH-1:0]    byte_offset;
        logic                                  overran;
        logic                                  newline_seen;
        logic [csvre_pkg::OFFSET_WIDTH-1:0]    first_nl;
        logic                                  scan_done;
    } t_state;

    t_state r_st;
    t_state n_st;

    logic                               v_emit;
    logic [csvre_pkg::OFFSET_WIDTH-1:0] v_off;
    csvre_pkg::t_kind                   v_kind;

    always_comb begin
        logic [csvre_pkg::OFFSET_WIDTH-1:0] p;
        logic [csvre_pkg::OFFSET_WIDTH-1:0] nxt;
        logic [7:0]                         c;
        logic                               run_plain;
        logic                               opens;

        n_st      = r_st;
        v_emit    = 1'b0;
        v_off     = '0;
        v_kind    = csvre_pkg::KIND_DATA_END;
        c         = i_item.data_byte;
        p         = r_st.byte_offset;
        nxt       = r_st.byte_offset;
        run_plain = 1'b0;
        opens     = 1'b0;

        if (i_item.scan_start) begin
            n_st.inside_quoted   = 1'b0;
            n_st.quote_pending   = 1'b0;
            n_st.cell_was_quoted = 1'b0;
            n_st.cell_only_space = 1'b1;
            n_st.at_resume_point = 1'b1;
            n_st.byte_offset     = '0;
            n_st.newline_seen    = 1'b0;
            n_st.first_nl        = '0;
            n_st.scan_done       = 1'b0;
            n_st.overran         = (i_cfg.max_record_bytes == 32'd0);
        end

        if (!n_st.scan_done) begin
            if (i_item.byte_present) begin
                p   = n_st.byte_offset;
                nxt = (p != csvre_pkg::OFF_MAX) ? p + 1'b1 : p;
                n_st.byte_offset     = nxt;
                n_st.at_resume_point = 1'b0;
                if (c == csvre_pkg::NL_CH && !n_st.newline_seen) begin
                    n_st.newline_seen = 1'b1;
                    n_st.first_nl     = p;
                end
                if (n_st.overran) begin
                    if (c == csvre_pkg::NL_CH) begin
                        v_emit = 1'b1;
                        v_off  = n_st.first_nl;
                        v_kind = csvre_pkg::KIND_FALLBACK_NL;
                    end
                end else if (n_st.inside_quoted) begin
                    if (n_st.quote_pending) begin
                        n_st.quote_pending = 1'b0;
                        if (c != csvre_pkg::QUOTE_CH) begin
                            n_st.inside_quoted   = 1'b0;
                            n_st.at_resume_point = 1'b1;
                            if (csvre_pkg::over_cap(p, i_cfg.max_record_bytes)) begin
                                n_st.overran = 1'b1;
                                if (n_st.newline_seen) begin
                                    v_emit = 1'b1;
                                    v_off  = n_st.first_nl;
                                    v_kind = csvre_pkg::KIND_FALLBACK_NL;
                                end
                            end
                            run_plain = !v_emit && !n_st.overran;
                        end
                    end else if (c == csvre_pkg::QUOTE_CH) begin
                        n_st.quote_pending = 1'b1;
                    end
                end else begin
                    run_plain = 1'b1;
                end

                if (run_plain) begin
                    if (c == csvre_pkg::NL_CH) begin
                        v_emit = 1'b1;
                        v_off  = p;
                        v_kind = csvre_pkg::KIND_QUOTED_NL;
                    end else if (c == i_cfg.separator_char) begin
                        n_st.cell_was_quoted = 1'b0;
                        n_st.cell_only_space = 1'b1;
                        n_st.at_resume_point = 1'b1;
                        if (csvre_pkg::over_cap(nxt, i_cfg.max_record_bytes)) begin
                            n_st.overran = 1'b1;
                            if (n_st.newline_seen) begin
                                v_emit = 1'b1;
                                v_off  = n_st.first_nl;
                                v_kind = csvre_pkg::KIND_FALLBACK_NL;
                            end
                        end
                    end else if (c == csvre_pkg::QUOTE_CH) begin
                        opens = !n_st.cell_was_quoted && n_st.cell_only_space;
                        n_st.cell_was_quoted = n_st.cell_was_quoted || opens;
                        n_st.cell_only_space = 1'b0;
                        if (opens) begin
                            n_st.inside_quoted = 1'b1;
                        end else begin
                            n_st.at_resume_point = 1'b1;
                            if (csvre_pkg::over_cap(nxt, i_cfg.max_record_bytes)) begin
                                n_st.overran = 1'b1;
                                if (n_st.newline_seen) begin
                                    v_emit = 1'b1;
                                    v_off  = n_st.first_nl;
                                    v_kind = csvre_pkg::KIND_FALLBACK_NL;
                                end
                            end
                        end
                    end else if (!csvre_pkg::is_space(c)) begin
                        n_st.cell_only_space = 1'b0;
                    end
                end
            end

            if (i_item.data_end && !v_emit) begin
                if (!n_st.overran && n_st.inside_quoted &&
                    csvre_pkg::over_cap(n_st.byte_offset, i_cfg.max_record_bytes)) begin
                    n_st.overran = 1'b1;
                end
                v_emit = 1'b1;
                if (n_st.overran) begin
                    if (n_st.newline_seen) begin
                        v_off  = n_st.first_nl;
                        v_kind = csvre_pkg::KIND_FALLBACK_NL;
                    end else begin
                        v_off  = n_st.byte_offset;
                        v_kind = csvre_pkg::KIND_FALLBACK_END;
                    end
                end else begin
                    v_off  = n_st.byte_offset;
                    v_kind = csvre_pkg::KIND_DATA_END;
                end
            end

            if (v_emit) begin
                n_st.scan_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.inside_quoted   <= 1'b0;
            r_st.quote_pending   <= 1'b0;
            r_st.cell_was_quoted <= 1'b0;
            r_st.cell_only_space <= 1'b1;
            r_st.at_resume_point <= 1'b1;
            r_st.byte_offset     <= '0;
            r_st.overran         <= 1'b0;
            r_st.newline_seen    <= 1'b0;
            r_st.first_nl        <= '0;
            r_st.scan_done       <= 1'b1;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_emit              = v_emit;
    assign o_result.end_offset = 32'(v_off);
    assign o_result.end_kind   = v_kind;

    // An idle framer ignores every beat that does not start a scan.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_st.scan_done && !i_item.scan_start |-> !o_emit)
        else $error("result produced while idle");

    // Every result closes the scan.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_emit |=> r_st.scan_done)
        else $error("scan still open after a result");

    // A pending quote can only exist inside a quoted field.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.quote_pending |-> r_st.inside_quoted)
        else $error("quote pending outside a quoted field");

    // An open scan is never both overrun and inside quotes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.scan_done |-> !(r_st.inside_quoted && r_st.overran))
        else $error("overrun inside a quoted field");

    // The offset never moves backwards within a scan.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_item.scan_start && !r_st.scan_done
        |=> r_st.byte_offset >= $past(r_st.byte_offset))
        else $error("byte offset went backwards");

endmodule

[hdl/csv_record_end_finder_top.sv]
// ----------------------------------------------------------------------------
// CSV record end finder
// Streams the bytes of a scan and reports where the CSV record ends.
// ----------------------------------------------------------------------------
// The block takes one byte beat per clock and never stalls the input while
// the result register is free or being drained; a beat that ends the record
// or the data leaves its result in the output register on the following
// clock. The only thing that holds the input back is a result waiting in the
// output register while the consumer keeps its ready low. Configuration
// writes are always taken and should be made only while no scan is active.
module csv_record_end_finder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  csvre_pkg::t_in                       i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output csvre_pkg::t_out                      o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [csvre_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);

    csvre_pkg::t_cfg r_cfg;
    logic            r_out_valid;
    csvre_pkg::t_out r_out;

    logic            in_accept;
    logic            emit;
    csvre_pkg::t_out result;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    csvre_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator_char   <= csvre_pkg::SEP_RESET;
            r_cfg.max_record_bytes <= csvre_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            case (csvre_pkg::t_cfg_idx'(i_cfg_index))
                csvre_pkg::CFG_SEPARATOR: r_cfg.separator_char   <= i_cfg_data[7:0];
                csvre_pkg::CFG_MAX_BYTES: r_cfg.max_record_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
